FILE: rtl/core/box_pair_iou_macros.svh
// Assertion macros used by the box pair IoU top level.
`ifndef BOX_PAIR_IOU_MACROS_SVH
`define BOX_PAIR_IOU_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BPIOU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BPIOU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bpiou_pkg.sv
// Types, widths and helpers for the box pair IoU pipeline.
package bpiou_pkg;

	localparam int COORD_BITS      = 16;
	localparam int RATIO_FRAC_BITS = 16;

	localparam int EXT_BITS   = COORD_BITS + 1;
	localparam int AREA_BITS  = 2 * COORD_BITS;
	localparam int DEN_BITS   = AREA_BITS + 1;
	localparam int UNI_BITS   = AREA_BITS + 2;
	localparam int RATIO_BITS = RATIO_FRAC_BITS + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_left;
		logic signed [COORD_BITS-1:0] a_top;
		logic signed [COORD_BITS-1:0] a_right;
		logic signed [COORD_BITS-1:0] a_bottom;
		logic signed [COORD_BITS-1:0] b_left;
		logic signed [COORD_BITS-1:0] b_top;
		logic signed [COORD_BITS-1:0] b_right;
		logic signed [COORD_BITS-1:0] b_bottom;
		logic                         row_end_in;
		logic                         matrix_end_in;
	} pair_t;

	typedef struct packed {
		logic [RATIO_BITS-1:0] overlap_ratio;
		logic                  empty_union;
		logic                  row_end_out;
		logic                  matrix_end_out;
	} iou_t;

	typedef struct packed {
		logic empty;
		logic sat;
		logic row_end;
		logic matrix_end;
	} tag_t;

	function automatic logic signed [EXT_BITS-1:0] ext(input logic signed [COORD_BITS-1:0] c);
		return {c[COORD_BITS-1], c};
	endfunction

	function automatic logic signed [EXT_BITS-1:0] smin(input logic signed [EXT_BITS-1:0] x,
			input logic signed [EXT_BITS-1:0] y);
		return (x < y) ? x : y;
	endfunction

	function automatic logic signed [EXT_BITS-1:0] smax(input logic signed [EXT_BITS-1:0] x,
			input logic signed [EXT_BITS-1:0] y);
		return (x > y) ? x : y;
	endfunction

endpackage

FILE: rtl/core/box_pair_iou.sv
// Top level: intersection over union of one pair of axis-aligned boxes per transfer.
// Stages: a transferred pair is registered through three arithmetic stages, one stage per
// quotient bit of the divider, and the output register.
// Throughput: one pair per cycle while the result side keeps taking; the stages are fully
// pipelined. Reset clears every stage valid bit and the output valid.
`include "box_pair_iou_macros.svh"

module box_pair_iou (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_ready,
	input  bpiou_pkg::pair_t  pair,
	output logic              iou_valid,
	input  logic              iou_ready,
	output bpiou_pkg::iou_t   iou
);

	localparam int CB = bpiou_pkg::COORD_BITS;
	localparam int EB = bpiou_pkg::EXT_BITS;
	localparam int AB = bpiou_pkg::AREA_BITS;
	localparam int UB = bpiou_pkg::UNI_BITS;
	localparam int DW = bpiou_pkg::DEN_BITS;
	localparam int N  = bpiou_pkg::RATIO_FRAC_BITS;

	// stage 1: overlap extents and box extents
	logic signed [EB-1:0] ix_s1, iy_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	bpiou_pkg::tag_t      tag_s1;
	logic                 vld_s1;
	logic                 rdy_s1;

	// stage 2: products
	logic [AB-1:0]        inter_s2, area_a_s2, area_b_s2;
	bpiou_pkg::tag_t      tag_s2;
	logic                 vld_s2;
	logic                 rdy_s2;

	// stage 3: union and special cases
	logic [DW-1:0]        num_s3, den_s3;
	bpiou_pkg::tag_t      tag_s3;
	logic                 vld_s3;
	logic                 rdy_s3;

	logic                 div_ready;

	assign rdy_s1     = !vld_s1 || rdy_s2;
	assign rdy_s2     = !vld_s2 || rdy_s3;
	assign rdy_s3     = !vld_s3 || div_ready;
	assign pair_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= pair_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pair_valid) begin
			ix_s1 <= bpiou_pkg::smin(bpiou_pkg::ext(pair.a_right), bpiou_pkg::ext(pair.b_right))
				- bpiou_pkg::smax(bpiou_pkg::ext(pair.a_left), bpiou_pkg::ext(pair.b_left));
			iy_s1 <= bpiou_pkg::smin(bpiou_pkg::ext(pair.a_bottom), bpiou_pkg::ext(pair.b_bottom))
				- bpiou_pkg::smax(bpiou_pkg::ext(pair.a_top), bpiou_pkg::ext(pair.b_top));
			aw_s1 <= bpiou_pkg::ext(pair.a_right) - bpiou_pkg::ext(pair.a_left);
			ah_s1 <= bpiou_pkg::ext(pair.a_bottom) - bpiou_pkg::ext(pair.a_top);
			bw_s1 <= bpiou_pkg::ext(pair.b_right) - bpiou_pkg::ext(pair.b_left);
			bh_s1 <= bpiou_pkg::ext(pair.b_bottom) - bpiou_pkg::ext(pair.b_top);
			tag_s1.empty      <= 1'b0;
			tag_s1.sat        <= 1'b0;
			tag_s1.row_end    <= pair.row_end_in;
			tag_s1.matrix_end <= pair.matrix_end_in;
		end
	end

	logic [CB-1:0]        iw, ih;
	logic [AB-1:0]        inter_c;
	logic signed [UB-1:0] prod_a, prod_b;

	assign iw      = ix_s1[EB-1] ? '0 : ix_s1[CB-1:0];
	assign ih      = iy_s1[EB-1] ? '0 : iy_s1[CB-1:0];
	assign inter_c = iw * ih;
	assign prod_a  = aw_s1 * ah_s1;
	assign prod_b  = bw_s1 * bh_s1;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			inter_s2  <= inter_c;
			area_a_s2 <= prod_a[UB-1] ? '0 : prod_a[AB-1:0];
			area_b_s2 <= prod_b[UB-1] ? '0 : prod_b[AB-1:0];
			tag_s2    <= tag_s1;
		end
	end

	logic signed [UB-1:0] uni;
	logic                 empty_c;
	logic                 sat_c;

	assign uni     = $signed({2'b00, area_a_s2}) + $signed({2'b00, area_b_s2})
		- $signed({2'b00, inter_s2});
	assign empty_c = uni[UB-1] || (uni == '0);
	assign sat_c   = !empty_c && ({2'b00, inter_s2} >= $unsigned(uni));

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			num_s3            <= {1'b0, inter_s2};
			den_s3            <= uni[DW-1:0];
			tag_s3.empty      <= empty_c;
			tag_s3.sat        <= sat_c;
			tag_s3.row_end    <= tag_s2.row_end;
			tag_s3.matrix_end <= tag_s2.matrix_end;
		end
	end

	bpiou_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_ready  (div_ready),
		.num       (num_s3),
		.den       (den_s3),
		.tag       (tag_s3),
		.out_valid (iou_valid),
		.out_ready (iou_ready),
		.out       (iou)
	);

	`BPIOU_ASSERT_NOW(a_empty_zero, iou_valid && iou.empty_union, iou.overlap_ratio == '0, "empty union with nonzero ratio")
	`BPIOU_ASSERT_NOW(a_ratio_max, iou_valid, iou.overlap_ratio <= {1'b1, {N{1'b0}}}, "ratio above one")
	`BPIOU_ASSERT_NOW(a_drain_ready, !iou_valid, pair_ready, "input stalled with output register empty")
	`BPIOU_ASSERT_NOW(a_flags_excl, vld_s3, !(tag_s3.empty && tag_s3.sat), "empty and saturate both set")
	`BPIOU_ASSERT_NEXT(a_s3_hold, vld_s3 && !div_ready, vld_s3 && $stable(num_s3) && $stable(den_s3), "stage 3 lost on stall")

endmodule

FILE: rtl/core/bpiou_div.sv
// Pipelined restoring divider: one quotient bit per stage, then rounding and output register.
module bpiou_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bpiou_pkg::DEN_BITS-1:0]      num,
	input  logic [bpiou_pkg::DEN_BITS-1:0]      den,
	input  bpiou_pkg::tag_t                     tag,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bpiou_pkg::iou_t                     out
);

	localparam int N  = bpiou_pkg::RATIO_FRAC_BITS;
	localparam int DW = bpiou_pkg::DEN_BITS;
	localparam int RB = bpiou_pkg::RATIO_BITS;

	logic [DW-1:0]   rem_s [1:N];
	logic [DW-1:0]   den_s [1:N];
	logic [N-1:0]    quo_s [1:N];
	bpiou_pkg::tag_t tag_s [1:N];
	logic [N:1]      vld_s;
	logic [N+1:1]    rdy;

	bpiou_pkg::iou_t out_q;
	logic            out_valid_q;

	genvar k;
	generate
		for (k = 1; k <= N; k++) begin : g_step
			logic [DW-1:0]   src_rem;
			logic [DW-1:0]   src_den;
			logic [N-1:0]    src_quo;
			bpiou_pkg::tag_t src_tag;
			logic            src_vld;
			logic [DW:0]     trial;
			logic [DW:0]     diff;
			logic            fits;

			if (k == 1) begin : g_first
				assign src_rem = num;
				assign src_den = den;
				assign src_quo = '0;
				assign src_tag = tag;
				assign src_vld = in_valid;
			end else begin : g_next
				assign src_rem = rem_s[k-1];
				assign src_den = den_s[k-1];
				assign src_quo = quo_s[k-1];
				assign src_tag = tag_s[k-1];
				assign src_vld = vld_s[k-1];
			end

			assign trial = {src_rem, 1'b0};
			assign diff  = trial - {1'b0, src_den};
			assign fits  = (trial >= {1'b0, src_den});
			assign rdy[k] = !vld_s[k] || rdy[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= src_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && src_vld) begin
					rem_s[k] <= fits ? diff[DW-1:0] : trial[DW-1:0];
					den_s[k] <= src_den;
					quo_s[k] <= {src_quo[N-2:0], fits};
					tag_s[k] <= src_tag;
				end
			end
		end
	endgenerate

	logic          round_up;
	logic [RB-1:0] rounded;
	logic [RB-1:0] ratio;

	assign round_up = ({rem_s[N], 1'b0} >= {1'b0, den_s[N]});
	assign rounded  = {1'b0, quo_s[N]} + RB'(round_up);

	always_comb begin
		priority if (tag_s[N].empty) begin
			ratio = '0;
		end else if (tag_s[N].sat) begin
			ratio = {1'b1, {N{1'b0}}};
		end else begin
			ratio = rounded;
		end
	end

	assign rdy[N+1] = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[N+1]) begin
			out_valid_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[N+1] && vld_s[N]) begin
			out_q.overlap_ratio  <= ratio;
			out_q.empty_union    <= tag_s[N].empty;
			out_q.row_end_out    <= tag_s[N].row_end;
			out_q.matrix_end_out <= tag_s[N].matrix_end;
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = out_valid_q;
	assign out       = out_q;

endmodule

FILE: sim/tb_top.sv
// Testbench for box_pair_iou: directed and random box pairs, checked against a built-in IoU predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam int PAIRS_PER_PHASE = 240;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             pair_valid = 1'b0;
	logic             pair_ready;
	bpiou_pkg::pair_t pair       = '0;
	logic             iou_valid;
	logic             iou_ready  = 1'b0;
	bpiou_pkg::iou_t  iou;

	bpiou_pkg::iou_t expected_iou[$];
	int              fail_count = 0;
	int              idle_pct   = 0;
	int              stall_pct  = 0;

	box_pair_iou dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair),
		.iou_valid  (iou_valid),
		.iou_ready  (iou_ready),
		.iou        (iou)
	);

	always #5 clk = ~clk;

	function automatic longint coord(input logic [bpiou_pkg::COORD_BITS-1:0] c);
		return longint'($signed(c));
	endfunction

	function automatic bpiou_pkg::iou_t iou_of_pair(input bpiou_pkg::pair_t p);
		longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
		longint iw, ih, inter, area_a, area_b, uni, quo, rem;
		bpiou_pkg::iou_t r;
		ax1 = coord(p.a_left);
		ay1 = coord(p.a_top);
		ax2 = coord(p.a_right);
		ay2 = coord(p.a_bottom);
		bx1 = coord(p.b_left);
		by1 = coord(p.b_top);
		bx2 = coord(p.b_right);
		by2 = coord(p.b_bottom);
		iw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
		ih = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter = iw * ih;
		area_a = (ax2 - ax1) * (ay2 - ay1);
		area_b = (bx2 - bx1) * (by2 - by1);
		if (area_a < 0) area_a = 0;
		if (area_b < 0) area_b = 0;
		uni = area_a + area_b - inter;
		r = '0;
		quo = 0;
		if (uni <= 0) begin
			r.empty_union = 1'b1;
		end else if (inter >= uni) begin
			quo = longint'(1) <<< bpiou_pkg::RATIO_FRAC_BITS;
		end else begin
			quo = (inter <<< bpiou_pkg::RATIO_FRAC_BITS) / uni;
			rem = (inter <<< bpiou_pkg::RATIO_FRAC_BITS) - quo * uni;
			if (2 * rem >= uni) quo = quo + 1;
		end
		r.overlap_ratio  = quo[bpiou_pkg::RATIO_BITS-1:0];
		r.row_end_out    = p.row_end_in;
		r.matrix_end_out = p.matrix_end_in;
		return r;
	endfunction

	function automatic bpiou_pkg::pair_t make_pair(input int al, input int at, input int ar,
			input int ab, input int bl, input int bt, input int br, input int bb,
			input logic row_end, input logic matrix_end);
		bpiou_pkg::pair_t p;
		p.a_left        = 16'(al);
		p.a_top         = 16'(at);
		p.a_right       = 16'(ar);
		p.a_bottom      = 16'(ab);
		p.b_left        = 16'(bl);
		p.b_top         = 16'(bt);
		p.b_right       = 16'(br);
		p.b_bottom      = 16'(bb);
		p.row_end_in    = row_end;
		p.matrix_end_in = matrix_end;
		return p;
	endfunction

	function automatic int rand_offset(input int span, input int sh);
		return (int'($urandom_range(2 * span)) - span) <<< sh;
	endfunction

	// Mostly well-formed boxes near each other, some flipped or zero-sized, some raw bits.
	function automatic bpiou_pkg::pair_t random_pair();
		bpiou_pkg::pair_t p;
		int               kind, sh, ax, ay, aw, ah, bx, by, bw, bh;
		logic             row_end, matrix_end;
		kind       = $urandom_range(99);
		row_end    = ($urandom_range(3) == 0);
		matrix_end = ($urandom_range(19) == 0);
		if (kind < 15) begin
			p = make_pair($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535), row_end, matrix_end);
		end else begin
			sh = $urandom_range(6);
			ax = rand_offset(8192, 0);
			ay = rand_offset(8192, 0);
			aw = int'($urandom_range(255)) <<< sh;
			ah = int'($urandom_range(255)) <<< sh;
			if ($urandom_range(9) == 0) begin
				bx = ax;
				by = ay;
				bw = aw;
				bh = ah;
			end else begin
				bx = ax + rand_offset(128, sh);
				by = ay + rand_offset(128, sh);
				bw = int'($urandom_range(255)) <<< sh;
				bh = int'($urandom_range(255)) <<< sh;
			end
			if (kind < 35) begin
				if ($urandom_range(1)) aw = -aw;
				if ($urandom_range(1)) ah = -ah;
				if ($urandom_range(1)) bw = -bw;
				if ($urandom_range(1)) bh = -bh;
				if ($urandom_range(3) == 0) aw = 0;
				if ($urandom_range(3) == 0) bh = 0;
			end
			p = make_pair(ax, ay, ax + aw, ay + ah, bx, by, bx + bw, by + bh,
				row_end, matrix_end);
		end
		return p;
	endfunction

	task automatic send_pair(input bpiou_pkg::pair_t p);
		if ($urandom_range(99) < idle_pct) begin
			pair_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		pair_valid <= 1'b1;
		pair       <= p;
		@(posedge clk);
		while (!pair_ready) @(posedge clk);
		expected_iou.push_back(iou_of_pair(p));
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pair(random_pair());
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : take_result
		bpiou_pkg::iou_t want;
		if (arst_n && iou_valid && iou_ready) begin
			if (expected_iou.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, got ratio %0d empty %0d",
					$time, iou.overlap_ratio, iou.empty_union);
				fail_count++;
			end else begin
				want = expected_iou.pop_front();
				check_field("overlap_ratio", 32'(want.overlap_ratio), 32'(iou.overlap_ratio));
				check_field("empty_union", 32'(want.empty_union), 32'(iou.empty_union));
				check_field("row_end_out", 32'(want.row_end_out), 32'(iou.row_end_out));
				check_field("matrix_end_out", 32'(want.matrix_end_out),
					32'(iou.matrix_end_out));
			end
		end
		iou_ready <= (int'($urandom_range(99)) >= stall_pct);
	end

	task automatic test_corner_cases();
		idle_pct  = 0;
		stall_pct = 0;
		send_pair(make_pair(0, 0, 16, 16, 0, 0, 16, 16, 1'b0, 1'b0));
		send_pair(make_pair(0, 0, 16, 16, 32, 32, 48, 48, 1'b1, 1'b0));
		send_pair(make_pair(0, 0, 16, 16, 16, 0, 32, 16, 1'b0, 1'b1));
		send_pair(make_pair(0, 0, 64, 64, 16, 16, 32, 32, 1'b1, 1'b1));
		send_pair(make_pair(0, 0, 32, 16, 16, 0, 48, 16, 1'b0, 1'b0));
		send_pair(make_pair(0, 0, 48, 48, 16, 16, 64, 64, 1'b0, 1'b0));
		send_pair(make_pair(0, 0, 1000, 1000, 0, 0, 1000, 1001, 1'b0, 1'b0));
		send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5, 1'b0, 1'b0));
		send_pair(make_pair(0, 16, 16, 0, 0, 32, 16, 0, 1'b0, 1'b0));
		send_pair(make_pair(16, 16, 0, 0, 0, 0, 16, 16, 1'b0, 1'b0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 16, 16, 1'b0, 1'b0));
		// half an LSB: rounds up
		send_pair(make_pair(0, 0, 256, 512, 0, 0, 1, 1, 1'b0, 1'b0));
		send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			1'b1, 1'b1));
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
			1'b0, 1'b0));
		send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
			1'b0, 1'b0));
		send_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1, 1'b0, 1'b0));
		send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768,
			1'b0, 1'b0));
		send_pair(make_pair(-32768, -32768, 32767, 32766, -32768, -32768, 32767, 32767,
			1'b0, 1'b0));
		send_pair(make_pair(21845, -21846, 21845, -21846, -21846, 21845, -21846, 21845,
			1'b1, 1'b0));
		send_pair(make_pair(-21846, 21845, -21846, 21845, 21845, -21846, 21845, -21846,
			1'b0, 1'b1));
	endtask

	task automatic test_streaming();
		idle_pct  = 0;
		stall_pct = 0;
		send_random(PAIRS_PER_PHASE);
	endtask

	task automatic test_sender_gaps();
		idle_pct  = 59;
		stall_pct = 0;
		send_random(PAIRS_PER_PHASE);
	endtask

	task automatic test_receiver_stalls();
		idle_pct  = 0;
		stall_pct = 59;
		send_random(PAIRS_PER_PHASE);
	endtask

	task automatic test_both_sides_idle();
		idle_pct  = 28;
		stall_pct = 28;
		send_random(PAIRS_PER_PHASE);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_sides_idle();
		pair_valid <= 1'b0;
		while (expected_iou.size() != 0) @(posedge clk);
		repeat (bpiou_pkg::RATIO_FRAC_BITS + 12) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
